@@ rtl/hpn_pkg.sv @@
// ----------------------------------------------------------------------------
// HEALPix neighbour finder package
// Shared widths, direction codes, pipeline payload types and the function
// that gives neighbouring base faces.
// ----------------------------------------------------------------------------
package hpn_pkg;

  // Coordinate width on a face, pixel width, and width of nside squared.
  localparam int CW    = 14;
  localparam int PW    = 30;
  localparam int NW    = 28;
  localparam int CODEW = 2 * CW;
  localparam int NDIR  = 8;

  typedef logic [CW-1:0] coord_t;

  // Directions in the order in which results leave the block.
  typedef enum logic [2:0] {
    DIR_E  = 3'd0,  // (+,0)
    DIR_NE = 3'd1,  // (+,+)
    DIR_N  = 3'd2,  // (0,+)
    DIR_NW = 3'd3,  // (-,+)
    DIR_W  = 3'd4,  // (-,0)
    DIR_SW = 3'd5,  // (-,-)
    DIR_S  = 3'd6,  // (0,-)
    DIR_SE = 3'd7   // (+,-)
  } dir_t;

  // One neighbour candidate.
  typedef struct packed {
    logic       ex;
    logic [3:0] face;
    coord_t     nx;
    coord_t     ny;
  } cand_t;

  // Payload of the front pipeline; fields are reused as the item moves on.
  typedef struct packed {
    logic [PW-1:0] pix;
    logic          inv;
    logic [3:0]    f;
    logic [NW-1:0] rem;
    logic [NW-1:0] orig;
    coord_t        q;
  } fr_t;

  // One item's full set of candidates, held by the serializer.
  typedef struct packed {
    cand_t [NDIR-1:0] c;
    logic             inv;
    logic [2:0]       last_dir;
  } job_t;

  // First stage of the result pipeline.
  typedef struct packed {
    logic [3:0] face;
    coord_t     nx;
    coord_t     ny;
    logic       last;
    logic       inv;
  } em1_t;

  // Second stage of the result pipeline: products are registered here.
  typedef struct packed {
    logic [31:0]      base;
    logic [NW-1:0]    prod;
    coord_t           ny;
    logic [CODEW-1:0] code;
    logic             last;
    logic             inv;
  } em2_t;

  // Base face across an edge or corner of face f.
  function automatic logic [3:0] face_step(logic [3:0] f, dir_t d);
    logic [1:0] fl;
    logic [3:0] r;
    fl = f[1:0];
    if (f <= 4'd3) begin
      case (d)
        DIR_E:   r = {2'b00, fl + 2'd1};
        DIR_N:   r = {2'b00, fl + 2'd3};
        DIR_NE:  r = {2'b00, fl + 2'd2};
        DIR_W:   r = f + 4'd4;
        DIR_S:   r = {2'b01, fl + 2'd1};
        default: r = f + 4'd8;
      endcase
    end else if (f >= 4'd8) begin
      case (d)
        DIR_E:   r = {2'b01, fl + 2'd1};
        DIR_N:   r = f - 4'd4;
        DIR_W:   r = {2'b10, fl + 2'd3};
        DIR_S:   r = {2'b10, fl + 2'd1};
        DIR_SW:  r = {2'b10, fl + 2'd2};
        default: r = f - 4'd8;
      endcase
    end else begin
      case (d)
        DIR_E:   r = f - 4'd4;
        DIR_N:   r = {2'b00, fl + 2'd3};
        DIR_W:   r = {2'b10, fl + 2'd3};
        DIR_S:   r = f + 4'd4;
        DIR_SE:  r = {2'b01, fl + 2'd1};
        default: r = {2'b01, fl - 2'd1};
      endcase
    end
    return r;
  endfunction

endpackage

@@ rtl/healpix_pixel_neighbours_core.sv @@
// ----------------------------------------------------------------------------
// HEALPix pixel neighbour finder
// Splits a fine pixel index into base face and face coordinates, finds the
// six to eight neighbouring pixels and sends them out one per transfer.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                                        | Direction
//   --------+----------------------------------------------+----------
//   input   | in_valid, in_stall, in_pixel_index           | in
//   result  | out_valid, out_stall, out_neighbour_index,   | out
//           | out_last, out_invalid                        |
//   config  | cfg_we, cfg_nside                            | in
//
// A pixel takes one walk of the shared result path, one step per direction
// in order, a missing corner before the end still taking its step and the
// walk ending at the last existing neighbour; an out-of-range pixel takes a
// single step. The serializer that walks directions sets the pixel rate; the
// front pipeline behind it takes one pixel per cycle while it has room.
// Reset clears all valid bits and sets nside to 1. A stall on the result
// side holds each full stage with no empty stage ahead of it; nothing is
// dropped or repeated.
module healpix_pixel_neighbours_core
  import hpn_pkg::*;
#(
  parameter int NSIDE_BITS = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [13:0]   cfg_nside,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [PW-1:0] in_pixel_index,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [PW-1:0] out_neighbour_index,
  output logic          out_last,
  output logic          out_invalid
);

  // Front stages: capture, coarse face, fine face, divider bits, decode.
  localparam int ST_DIV  = 3;
  localparam int ST_DEC  = ST_DIV + CW;
  localparam int NF      = ST_DEC + 1;

  // --------------------------------------------------------------------------
  // Coordinate packing helpers.
  // --------------------------------------------------------------------------
  function automatic logic [CODEW-1:0] interleave(coord_t x, coord_t y);
    logic [CODEW-1:0] r;
    r = '0;
    for (int b = 0; b < NSIDE_BITS; b++) begin
      r[2*b]   = x[b];
      r[2*b+1] = y[b];
    end
    return r;
  endfunction

  function automatic coord_t deint(logic [NW-1:0] p, int ofs);
    coord_t r;
    r = '0;
    for (int b = 0; b < NSIDE_BITS; b++) begin
      r[b] = p[2*b+ofs];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Neighbour candidates for face f at (x, y), edge coordinate m.
  // --------------------------------------------------------------------------
  function automatic job_t nb_calc(logic [3:0] f, coord_t x, coord_t y, coord_t m,
                                   logic inv);
    job_t   j;
    logic   north;
    logic   south;
    logic   equ;
    logic   xm;
    logic   ym;
    logic   x0;
    logic   y0;
    coord_t nx;
    coord_t ny;
    coord_t t;
    north = (f <= 4'd3);
    south = (f >= 4'd8);
    equ   = !north && !south;
    xm    = (x == m);
    ym    = (y == m);
    x0    = (x == '0);
    y0    = (y == '0);
    j     = '0;
    j.inv = inv;
    for (int d = 0; d < NDIR; d++) begin
      j.c[d].ex = 1'b1;
    end

    // East.
    if (xm) begin
      j.c[DIR_E].face = face_step(f, DIR_E);
      j.c[DIR_E].nx   = north ? y : '0;
      j.c[DIR_E].ny   = north ? m : y;
    end else begin
      j.c[DIR_E].face = f;
      j.c[DIR_E].nx   = x + 1'b1;
      j.c[DIR_E].ny   = y;
    end

    // North-east corner; north faces swap coordinates across the edge.
    nx = xm ? '0 : x + 1'b1;
    ny = ym ? '0 : y + 1'b1;
    if (north) begin
      if (xm) nx = m;
      if (ym) ny = m;
      if (xm || ym) begin
        t  = nx;
        nx = ny;
        ny = t;
      end
    end
    j.c[DIR_NE].nx = nx;
    j.c[DIR_NE].ny = ny;
    if (xm && ym) begin
      j.c[DIR_NE].ex   = !equ;
      j.c[DIR_NE].face = face_step(f, DIR_NE);
    end else if (xm) begin
      j.c[DIR_NE].face = face_step(f, DIR_E);
    end else if (ym) begin
      j.c[DIR_NE].face = face_step(f, DIR_N);
    end else begin
      j.c[DIR_NE].face = f;
    end

    // North.
    if (ym) begin
      j.c[DIR_N].face = face_step(f, DIR_N);
      j.c[DIR_N].nx   = north ? m : x;
      j.c[DIR_N].ny   = north ? x : '0;
    end else begin
      j.c[DIR_N].face = f;
      j.c[DIR_N].nx   = x;
      j.c[DIR_N].ny   = y + 1'b1;
    end

    // North-west corner.
    nx = x0 ? m : x - 1'b1;
    ny = ym ? '0 : y + 1'b1;
    if (x0 && ym) begin
      j.c[DIR_NW].ex   = equ;
      j.c[DIR_NW].face = face_step(f, DIR_NW);
      j.c[DIR_NW].nx   = nx;
      j.c[DIR_NW].ny   = ny;
    end else if (x0) begin
      j.c[DIR_NW].face = face_step(f, DIR_W);
      j.c[DIR_NW].nx   = south ? ny : nx;
      j.c[DIR_NW].ny   = south ? '0 : ny;
    end else if (ym) begin
      j.c[DIR_NW].face = face_step(f, DIR_N);
      j.c[DIR_NW].nx   = north ? m : nx;
      j.c[DIR_NW].ny   = north ? nx : ny;
    end else begin
      j.c[DIR_NW].face = f;
      j.c[DIR_NW].nx   = nx;
      j.c[DIR_NW].ny   = ny;
    end

    // West.
    if (x0) begin
      j.c[DIR_W].face = face_step(f, DIR_W);
      j.c[DIR_W].nx   = south ? y : m;
      j.c[DIR_W].ny   = south ? '0 : y;
    end else begin
      j.c[DIR_W].face = f;
      j.c[DIR_W].nx   = x - 1'b1;
      j.c[DIR_W].ny   = y;
    end

    // South-west corner; south faces swap coordinates across the edge.
    nx = x0 ? m : x - 1'b1;
    ny = y0 ? m : y - 1'b1;
    if (south) begin
      if (x0) nx = '0;
      if (y0) ny = '0;
      if (x0 || y0) begin
        t  = nx;
        nx = ny;
        ny = t;
      end
    end
    j.c[DIR_SW].nx = nx;
    j.c[DIR_SW].ny = ny;
    if (x0 && y0) begin
      j.c[DIR_SW].ex   = !equ;
      j.c[DIR_SW].face = face_step(f, DIR_SW);
    end else if (x0) begin
      j.c[DIR_SW].face = face_step(f, DIR_W);
    end else if (y0) begin
      j.c[DIR_SW].face = face_step(f, DIR_S);
    end else begin
      j.c[DIR_SW].face = f;
    end

    // South.
    if (y0) begin
      j.c[DIR_S].face = face_step(f, DIR_S);
      j.c[DIR_S].nx   = south ? '0 : x;
      j.c[DIR_S].ny   = south ? x : m;
    end else begin
      j.c[DIR_S].face = f;
      j.c[DIR_S].nx   = x;
      j.c[DIR_S].ny   = y - 1'b1;
    end

    // South-east corner.
    nx = xm ? '0 : x + 1'b1;
    ny = y0 ? m : y - 1'b1;
    if (xm && y0) begin
      j.c[DIR_SE].ex   = equ;
      j.c[DIR_SE].face = face_step(f, DIR_SE);
      j.c[DIR_SE].nx   = nx;
      j.c[DIR_SE].ny   = ny;
    end else if (xm) begin
      j.c[DIR_SE].face = face_step(f, DIR_E);
      j.c[DIR_SE].nx   = north ? ny : nx;
      j.c[DIR_SE].ny   = north ? m : ny;
    end else if (y0) begin
      j.c[DIR_SE].face = face_step(f, DIR_S);
      j.c[DIR_SE].nx   = south ? '0 : nx;
      j.c[DIR_SE].ny   = south ? nx : ny;
    end else begin
      j.c[DIR_SE].face = f;
      j.c[DIR_SE].nx   = nx;
      j.c[DIR_SE].ny   = ny;
    end

    // The run ends at the highest direction that has a neighbour.
    j.last_dir = 3'(DIR_S);
    for (int d = 0; d < NDIR; d++) begin
      if (j.c[d].ex) j.last_dir = 3'(d);
    end
    return j;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration and values derived from it.
  // --------------------------------------------------------------------------
  logic [13:0]   nside_r;
  logic [NW-1:0] ns2_r;
  logic          pow4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nside_r <= 14'd1;
      ns2_r   <= NW'(1);
      pow4_r  <= 1'b1;
    end else begin
      if (cfg_we) nside_r <= cfg_nside;
      ns2_r  <= NW'(nside_r) * NW'(nside_r);
      pow4_r <= (nside_r != '0) && ((nside_r & (nside_r - 1'b1)) == '0) &&
                ((nside_r & 14'h1555) != '0);
    end
  end

  // --------------------------------------------------------------------------
  // Front pipeline: face split, division into coordinates, decode.
  // --------------------------------------------------------------------------
  fr_t          fr_r   [NF];
  fr_t          fr_nxt [NF];
  logic [NF-1:0] fv_r;
  logic [NF:0]   frdy;
  logic          ser_rdy;

  // Each stage takes new data when it is empty or its content moves on.
  always_comb begin
    frdy[NF] = ser_rdy;
    for (int i = NF - 1; i >= 0; i--) begin
      frdy[i] = !fv_r[i] || frdy[i+1];
    end
  end

  assign in_stall = !frdy[0];

  // Capture stage.
  always_comb begin
    fr_nxt[0]     = fr_r[0];
    fr_nxt[0].pix = in_pixel_index;
  end

  // Coarse face group from 4*nside^2 and 8*nside^2, plus range check.
  always_comb begin
    logic [32:0] p;
    logic [32:0] q4;
    logic [32:0] q8;
    logic [32:0] q12;
    logic        g1;
    logic        g2;
    p   = 33'(fr_r[0].pix);
    q4  = {3'b000, ns2_r, 2'b00};
    q8  = {2'b00, ns2_r, 3'b000};
    q12 = q4 + q8;
    g2  = (p >= q8);
    g1  = (p >= q4);
    fr_nxt[1]     = fr_r[0];
    fr_nxt[1].inv = (p >= q12);
    fr_nxt[1].f   = g2 ? 4'd8 : (g1 ? 4'd4 : 4'd0);
    fr_nxt[1].pix = g2 ? PW'(p - q8) : (g1 ? PW'(p - q4) : PW'(p));
  end

  // Fine face within the group and the in-face index.
  always_comb begin
    logic [PW-1:0] r;
    logic [PW-1:0] n1;
    logic [PW-1:0] n2;
    logic [PW-1:0] n3;
    logic [PW-1:0] sel;
    logic [1:0]    jj;
    r  = fr_r[1].pix;
    n1 = PW'(ns2_r);
    n2 = {1'b0, ns2_r, 1'b0};
    n3 = n1 + n2;
    if (r >= n3) begin
      jj  = 2'd3;
      sel = n3;
    end else if (r >= n2) begin
      jj  = 2'd2;
      sel = n2;
    end else if (r >= n1) begin
      jj  = 2'd1;
      sel = n1;
    end else begin
      jj  = 2'd0;
      sel = '0;
    end
    fr_nxt[2]      = fr_r[1];
    fr_nxt[2].f    = {fr_r[1].f[3:2], jj};
    fr_nxt[2].rem  = NW'(r - sel);
    fr_nxt[2].orig = NW'(r - sel);
    fr_nxt[2].q    = '0;
  end

  // Restoring divider by nside, one quotient bit per stage, high bit first.
  for (genvar k = 0; k < CW; k++) begin : g_div
    localparam int B = CW - 1 - k;
    always_comb begin
      logic [NW-1:0] dv;
      dv = NW'(nside_r) << B;
      fr_nxt[ST_DIV+k] = fr_r[ST_DIV+k-1];
      if (fr_r[ST_DIV+k-1].rem >= dv) begin
        fr_nxt[ST_DIV+k].rem  = fr_r[ST_DIV+k-1].rem - dv;
        fr_nxt[ST_DIV+k].q[B] = 1'b1;
      end
    end
  end

  // Decode: bit interleaving for powers of four, row-major otherwise.
  always_comb begin
    fr_nxt[ST_DEC]   = fr_r[ST_DEC-1];
    fr_nxt[ST_DEC].q = pow4_r ? deint(fr_r[ST_DEC-1].orig, 0) : fr_r[ST_DEC-1].q;
    fr_nxt[ST_DEC].rem = pow4_r ? NW'(deint(fr_r[ST_DEC-1].orig, 1))
                                : fr_r[ST_DEC-1].rem;
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      for (int i = 0; i < NF; i++) begin
        if (frdy[i]) fv_r[i] <= (i == 0) ? in_valid : fv_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NF; i++) begin
      if (frdy[i]) fr_r[i] <= fr_nxt[i];
    end
  end

  // --------------------------------------------------------------------------
  // Neighbour stage and serializer: one direction per cycle unless the result side stalls.
  // --------------------------------------------------------------------------
  job_t       job_r;
  job_t       job_nxt;
  logic       busy_r;
  logic [2:0] dir_r;
  cand_t      cur;
  logic       done;
  logic       step;
  logic       e1_rdy;

  always_comb begin
    job_nxt = nb_calc(fr_r[NF-1].f, fr_r[NF-1].q, coord_t'(fr_r[NF-1].rem),
                      nside_r - 1'b1, fr_r[NF-1].inv);
  end

  assign cur     = job_r.c[dir_r];
  assign done    = job_r.inv || (dir_r == job_r.last_dir);
  assign step    = busy_r && e1_rdy;
  assign ser_rdy = !busy_r || (step && done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dir_r  <= '0;
    end else if (fv_r[NF-1] && ser_rdy) begin
      busy_r <= 1'b1;
      dir_r  <= '0;
    end else if (step) begin
      if (done) busy_r <= 1'b0;
      dir_r <= dir_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fv_r[NF-1] && ser_rdy) job_r <= job_nxt;
  end

  // --------------------------------------------------------------------------
  // Result pipeline: select, multiply, add.
  // --------------------------------------------------------------------------
  em1_t e1_r;
  em1_t e1_nxt;
  logic e1v_r;
  em2_t e2_r;
  em2_t e2_nxt;
  logic e2v_r;
  logic e2_rdy;
  logic o_rdy;
  logic          out_valid_r;
  logic [PW-1:0] out_index_r;
  logic [PW-1:0] out_index_nxt;
  logic          out_last_r;
  logic          out_invalid_r;

  assign o_rdy  = !out_valid_r || !out_stall;
  assign e2_rdy = !e2v_r || o_rdy;
  assign e1_rdy = !e1v_r || e2_rdy;

  always_comb begin
    e1_nxt.face = cur.face;
    e1_nxt.nx   = cur.nx;
    e1_nxt.ny   = cur.ny;
    e1_nxt.last = done;
    e1_nxt.inv  = job_r.inv;
  end

  always_comb begin
    e2_nxt.base = 32'(ns2_r) * 32'(e1_r.face);
    e2_nxt.prod = NW'(nside_r) * NW'(e1_r.nx);
    e2_nxt.ny   = e1_r.ny;
    e2_nxt.code = interleave(e1_r.nx, e1_r.ny);
    e2_nxt.last = e1_r.last;
    e2_nxt.inv  = e1_r.inv;
  end

  always_comb begin
    logic [32:0] sum;
    sum = 33'(e2_r.base) + (pow4_r ? 33'(e2_r.code)
                                   : 33'(e2_r.prod) + 33'(e2_r.ny));
    out_index_nxt = e2_r.inv ? '0 : sum[PW-1:0];
  end

  // Valid bits of the result pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1v_r       <= 1'b0;
      e2v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (e1_rdy) e1v_r <= step && (job_r.inv || cur.ex);
      if (e2_rdy) e2v_r <= e1v_r;
      if (o_rdy)  out_valid_r <= e2v_r;
    end
  end

  // Payload of the result pipeline.
  always_ff @(posedge clk) begin
    if (e1_rdy) e1_r <= e1_nxt;
    if (e2_rdy) e2_r <= e2_nxt;
    if (o_rdy) begin
      out_index_r   <= out_index_nxt;
      out_last_r    <= e2_r.last;
      out_invalid_r <= e2_r.inv;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_neighbour_index = out_index_r;
  assign out_last            = out_last_r;
  assign out_invalid         = out_invalid_r;

endmodule

@@ rtl/hpn_checker.sv @@
// ----------------------------------------------------------------------------
// HEALPix neighbour finder checker
// Watches the ports of the core and flags result transfers that break its
// rules for invalid pixels, reset and stalls.
// ----------------------------------------------------------------------------
module hpn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [13:0] cfg_nside,
  input logic        in_valid,
  input logic        in_stall,
  input logic [29:0] in_pixel_index,
  input logic        out_valid,
  input logic        out_stall,
  input logic [29:0] out_neighbour_index,
  input logic        out_last,
  input logic        out_invalid
);

  // An out-of-range pixel gives a single result.
  a_inv_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_last)
    else $error("invalid result is not marked last");

  // An out-of-range pixel reports index zero.
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_neighbour_index == 30'd0)
    else $error("invalid result carries a nonzero index");

  // Reset empties the result register.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_neighbour_index) &&
                               $stable(out_last) && $stable(out_invalid))
    else $error("stalled result changed");

endmodule

bind healpix_pixel_neighbours_core hpn_checker u_hpn_checker (.*);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// HEALPix neighbour finder testbench
// Drives fine pixel indices over several nside settings, predicts every
// neighbour transfer in a scoreboard and compares the result channel field
// by field, with random idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb
  import hpn_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_BITS   = 13;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct {
    logic [29:0] nbr;
    logic        last;
    logic        inv;
  } nbr_result_t;

  // Neighbour scoreboard: its own copy of nside and the queue of results
  // still owed by the block.
  class nbr_scoreboard;
    longint unsigned ns;
    nbr_result_t     owed[$];
    int              errors;

    function new();
      ns     = 1;
      errors = 0;
    endfunction

    function bit grid_pow4();
      return ns != 0 && (ns & (ns - 1)) == 0 && (ns & 64'h5555555555555555) != 0;
    endfunction

    function longint unsigned grid_code(longint unsigned x, longint unsigned y);
      longint unsigned r;
      r = 0;
      if (!grid_pow4()) return x * ns + y;
      for (int b = 0; b < GRID_BITS; b++) begin
        r |= ((x >> b) & 1) << (2 * b);
        r |= ((y >> b) & 1) << (2 * b + 1);
      end
      return r;
    endfunction

    // Face across an edge or corner, by direction.
    function longint unsigned next_face(longint unsigned f, dir_t d);
      if (f <= 3) begin
        case (d)
          DIR_E:   return (f + 1) % 4;
          DIR_N:   return (f + 3) % 4;
          DIR_NE:  return (f + 2) % 4;
          DIR_W:   return f + 4;
          DIR_S:   return 4 + (f + 1) % 4;
          default: return f + 8;
        endcase
      end else if (f >= 8) begin
        case (d)
          DIR_E:   return 4 + (f + 1) % 4;
          DIR_N:   return f - 4;
          DIR_W:   return 8 + (f + 3) % 4;
          DIR_S:   return 8 + (f + 1) % 4;
          DIR_SW:  return 8 + (f + 2) % 4;
          default: return f - 8;
        endcase
      end
      case (d)
        DIR_E:   return f - 4;
        DIR_N:   return (f + 3) % 4;
        DIR_W:   return 8 + (f + 3) % 4;
        DIR_S:   return f + 4;
        DIR_SE:  return 4 + (f + 1) % 4;
        default: return 4 + (f - 1) % 4;
      endcase
    endfunction

    function void owe(longint unsigned f, longint unsigned x, longint unsigned y);
      nbr_result_t r;
      longint unsigned v;
      v     = f * ns * ns + grid_code(x, y);
      r.nbr  = v[29:0];
      r.last = 1'b0;
      r.inv  = 1'b0;
      owed.push_back(r);
    endfunction

    // Notes one accepted pixel and queues the neighbours it must produce.
    function void note_pixel(logic [29:0] pix_in);
      longint unsigned pix, ns2, f, p, x, y, nx, ny, t, m;
      bit north, south, equ;
      nbr_result_t r;
      pix = pix_in;
      ns2 = ns * ns;
      if (ns == 0 || pix >= 12 * ns2) begin
        r.nbr  = '0;
        r.last = 1'b1;
        r.inv  = 1'b1;
        owed.push_back(r);
        return;
      end
      f = pix / ns2;
      p = pix % ns2;
      if (!grid_pow4()) begin
        x = p / ns;
        y = p % ns;
      end else begin
        x = 0;
        y = 0;
        for (int b = 0; b < GRID_BITS; b++) begin
          x |= ((p >> (2 * b)) & 1) << b;
          y |= ((p >> (2 * b + 1)) & 1) << b;
        end
      end
      m     = ns - 1;
      north = f <= 3;
      south = f >= 8;
      equ   = !north && !south;

      // East.
      if (x == m) begin
        if (north) owe(next_face(f, DIR_E), y, m);
        else owe(next_face(f, DIR_E), 0, y);
      end else owe(f, x + 1, y);

      // North-east; north faces swap coordinates across their high edges.
      nx = (x == m) ? 0 : x + 1;
      ny = (y == m) ? 0 : y + 1;
      if (north) begin
        if (x == m) nx = m;
        if (y == m) ny = m;
        if (x == m || y == m) begin
          t = nx; nx = ny; ny = t;
        end
      end
      if (x == m && y == m) begin
        if (!equ) owe(next_face(f, DIR_NE), nx, ny);
      end else if (x == m) owe(next_face(f, DIR_E), nx, ny);
      else if (y == m) owe(next_face(f, DIR_N), nx, ny);
      else owe(f, nx, ny);

      // North.
      if (y == m) begin
        if (north) owe(next_face(f, DIR_N), m, x);
        else owe(next_face(f, DIR_N), x, 0);
      end else owe(f, x, y + 1);

      // North-west.
      nx = (x == 0) ? m : x - 1;
      ny = (y == m) ? 0 : y + 1;
      if (x == 0 && y == m) begin
        if (equ) owe(next_face(f, DIR_NW), nx, ny);
      end else if (x == 0) begin
        if (south) owe(next_face(f, DIR_W), ny, 0);
        else owe(next_face(f, DIR_W), nx, ny);
      end else if (y == m) begin
        if (north) owe(next_face(f, DIR_N), m, nx);
        else owe(next_face(f, DIR_N), nx, ny);
      end else owe(f, nx, ny);

      // West.
      if (x == 0) begin
        if (south) owe(next_face(f, DIR_W), y, 0);
        else owe(next_face(f, DIR_W), m, y);
      end else owe(f, x - 1, y);

      // South-west; south faces swap across their low edges.
      nx = (x == 0) ? m : x - 1;
      ny = (y == 0) ? m : y - 1;
      if (south) begin
        if (x == 0) nx = 0;
        if (y == 0) ny = 0;
        if (x == 0 || y == 0) begin
          t = nx; nx = ny; ny = t;
        end
      end
      if (x == 0 && y == 0) begin
        if (!equ) owe(next_face(f, DIR_SW), nx, ny);
      end else if (x == 0) owe(next_face(f, DIR_W), nx, ny);
      else if (y == 0) owe(next_face(f, DIR_S), nx, ny);
      else owe(f, nx, ny);

      // South.
      if (y == 0) begin
        if (south) owe(next_face(f, DIR_S), 0, x);
        else owe(next_face(f, DIR_S), x, m);
      end else owe(f, x, y - 1);

      // South-east.
      nx = (x == m) ? 0 : x + 1;
      ny = (y == 0) ? m : y - 1;
      if (x == m && y == 0) begin
        if (equ) owe(next_face(f, DIR_SE), nx, ny);
      end else if (x == m) begin
        if (north) owe(next_face(f, DIR_E), ny, m);
        else owe(next_face(f, DIR_E), nx, ny);
      end else if (y == 0) begin
        if (south) owe(next_face(f, DIR_S), 0, nx);
        else owe(next_face(f, DIR_S), nx, ny);
      end else owe(f, nx, ny);

      owed[owed.size() - 1].last = 1'b1;
    endfunction

    // Compares one result transfer with the oldest owed neighbour.
    function void check_result(logic [29:0] nbr, logic last, logic inv);
      nbr_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result nbr=%0d last=%0b invalid=%0b",
                 $time, nbr, last, inv);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (nbr !== e.nbr) begin
        $display("%0t: neighbour_index expected %0d actual %0d", $time, e.nbr, nbr);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
      if (inv !== e.inv) begin
        $display("%0t: invalid expected %0b actual %0b", $time, e.inv, inv);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [13:0] cfg_nside;
  logic        in_valid;
  logic        in_stall;
  logic [29:0] in_pixel_index;
  logic        out_valid;
  logic        out_stall;
  logic [29:0] out_neighbour_index;
  logic        out_last;
  logic        out_invalid;

  nbr_scoreboard sb = new();
  bit            quiet_tail;
  int            cycles;

  healpix_pixel_neighbours_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_nside           (cfg_nside),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pixel_index      (in_pixel_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_neighbour_index (out_neighbour_index),
    .out_last            (out_last),
    .out_invalid         (out_invalid)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Monitors: note accepted pixels, check accepted results, bound the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) sb.note_pixel(in_pixel_index);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_neighbour_index, out_last, out_invalid);
  end

  // Result side stalls in random bursts, none in the tail of the run.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      if (!quiet_tail) repeat ($urandom_range(0, 15)) @(posedge clk);
    end
  end

  task automatic write_nside(logic [13:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_nside <= v;
    sb.ns = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Presents one pixel, after an optional idle burst, and waits for its transfer.
  task automatic send_pixel(logic [29:0] pix);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_index <= pix;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Random pixel: mostly in range with coordinates pulled toward face edges.
  function automatic logic [29:0] pick_pixel();
    longint unsigned total, m, x, y, v;
    int k;
    if (sb.ns == 0) return 30'($urandom);
    total = 12 * sb.ns * sb.ns;
    if ($urandom_range(0, 9) == 0 && total < 64'h40000000)
      return 30'($urandom_range(32'h3FFFFFFF, 32'(total)));
    m = sb.ns - 1;
    k = $urandom_range(0, 2);
    x = (k == 0) ? 0 : (k == 1) ? m : $urandom_range(m, 0);
    k = $urandom_range(0, 2);
    y = (k == 0) ? 0 : (k == 1) ? m : $urandom_range(m, 0);
    v = $urandom_range(0, 11) * sb.ns * sb.ns + sb.grid_code(x, y);
    return v[29:0];
  endfunction

  initial begin
    logic [13:0]     settings[10] = '{1, 2, 3, 4, 5, 16, 4096, 8192, 16383, 0};
    longint unsigned total;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_nside      = '0;
    in_valid       = 1'b0;
    in_pixel_index = '0;
    quiet_tail     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int s = 0; s < 10; s++) begin
      write_nside(settings[s]);
      // Directed: first and last pixel in range, first out of range, all ones.
      total = 12 * sb.ns * sb.ns;
      send_pixel('0);
      if (total != 0 && total <= 64'h40000000) begin
        send_pixel(30'(total - 1));
        if (total < 64'h40000000) send_pixel(30'(total));
      end
      send_pixel('1);
      if (s == 9) quiet_tail = 1'b1;
      for (int i = 0; i < 45; i++) send_pixel(pick_pixel());
      drain();
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
